/* rtl/lpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg
// Types, constants and helpers shared by the line point rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS = 6;
    // Error term and increments: 2*minor - 2*major down to -(2^(COORD_BITS+1) - 2)
    localparam int ERR_BITS = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef struct packed {
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } line_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   is_last;
    } point_t;

    typedef struct packed {
        logic y_neg;
        logic y_move;
        logic x_neg;
        logic x_move;
    } step_t;

    // Setup of one line, as handed from the front to the walker
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t stop_coord;
        err_t   error_init;
        err_t   inc_minor_step;
        err_t   inc_no_step;
        step_t  steps;
        logic   x_major;
        logic   single;
    } walk_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } walk_state_t;

    function automatic coord_t step_coord(coord_t c, logic move, logic neg);
        coord_t r;
        if (!move)
        begin
            r = c;
        end
        else if (neg)
        begin
            r = c - coord_t'(1);
        end
        else
        begin
            r = c + coord_t'(1);
        end
        return r;
    endfunction

endpackage

/* rtl/line_point_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_point_rasterizer
// Bresenham line point generator: one line request in, its points out.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     push / full        line  (x_start, y_start, x_end, y_end)
//  result    empty / pop        point (point_x, point_y, is_last)
//
//  A line of major length N gives N points (one for a degenerate line).
//  The walker loads a setup while idle, then emits a point per cycle unless
//  the result stalls; the walker's step loop sets the rate.
//  Up to QUEUE_DEPTH classified lines wait ahead of the walker.
//  Reset empties the queue and the output register and idles the walker.
//  A stalled result holds the walker; push stalls only when the queue fills.
// ----------------------------------------------------------------------------
module line_point_rasterizer
    import lpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  line_t  line,
    output logic   empty,
    input  logic   pop,
    output point_t point
);

    walk_cmd_t front_cmd;
    walk_cmd_t q_data;
    logic      q_empty;
    logic      q_pop;

    lpr_front u_front (
        .line (line),
        .cmd  (front_cmd)
    );

    lpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    lpr_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .point   (point),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

/* rtl/lpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_front
// Classifies a line request: deltas, step directions, major axis, stop
// coordinate, initial error and both error increments.
// ----------------------------------------------------------------------------
module lpr_front
    import lpr_pkg::*;
(
    input  line_t     line,
    output walk_cmd_t cmd
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    coord_t                     adx;
    coord_t                     ady;
    err_t                       major_e;
    err_t                       minor_e;
    logic                       x_major;

    assign dx = $signed({1'b0, line.x_end}) - $signed({1'b0, line.x_start});
    assign dy = $signed({1'b0, line.y_end}) - $signed({1'b0, line.y_start});

    assign adx = dx[COORD_BITS] ? coord_t'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? coord_t'(-dy) : dy[COORD_BITS-1:0];

    // Ties go to y
    assign x_major = adx > ady;
    assign major_e = x_major ? err_t'(adx) : err_t'(ady);
    assign minor_e = x_major ? err_t'(ady) : err_t'(adx);

    always_comb
    begin
        cmd.start_x        = line.x_start;
        cmd.start_y        = line.y_start;
        cmd.stop_coord     = x_major ? line.x_end : line.y_end;
        cmd.error_init     = minor_e + minor_e - major_e;
        cmd.inc_minor_step = minor_e + minor_e - major_e - major_e;
        cmd.inc_no_step    = minor_e + minor_e;
        cmd.steps.x_move   = dx != '0;
        cmd.steps.x_neg    = dx[COORD_BITS];
        cmd.steps.y_move   = dy != '0;
        cmd.steps.y_neg    = dy[COORD_BITS];
        cmd.x_major        = x_major;
        cmd.single         = (line.x_start == line.x_end) && (line.y_start == line.y_end);
    end

endmodule

/* rtl/lpr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_queue
// Small first-in first-out queue of line setups between front and walker.
// ----------------------------------------------------------------------------
module lpr_queue
    import lpr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  walk_cmd_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output walk_cmd_t rd_data,
    output logic      empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    walk_cmd_t           mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = count_reg == CNT_BITS'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count above depth");

endmodule

/* rtl/lpr_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_walker
// Walks one line setup a point per cycle into a one-entry output register, holding while a waiting point is not popped.
// ----------------------------------------------------------------------------
module lpr_walker
    import lpr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  walk_cmd_t q_data,
    input  logic      q_empty,
    output logic      q_pop,
    output point_t    point,
    output logic      empty,
    input  logic      pop
);

    walk_state_t state_reg;
    walk_state_t state_next;
    coord_t      cur_x_reg;
    coord_t      cur_x_next;
    coord_t      cur_y_reg;
    coord_t      cur_y_next;
    coord_t      stop_reg;
    err_t        err_reg;
    err_t        err_next;
    err_t        inc_minor_reg;
    err_t        inc_no_reg;
    step_t       steps_reg;
    logic        x_major_reg;
    logic        single_reg;
    point_t      out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_pop;
    logic        emit;
    logic        minor_step;
    coord_t      major_next;
    logic        last;

    assign out_pop    = pop && out_valid_reg;
    assign minor_step = !err_reg[ERR_BITS-1];

    assign cur_x_next = (x_major_reg || minor_step)
                      ? step_coord(cur_x_reg, steps_reg.x_move, steps_reg.x_neg) : cur_x_reg;
    assign cur_y_next = (!x_major_reg || minor_step)
                      ? step_coord(cur_y_reg, steps_reg.y_move, steps_reg.y_neg) : cur_y_reg;
    assign err_next   = minor_step ? err_reg + inc_minor_reg : err_reg + inc_no_reg;
    assign major_next = x_major_reg ? cur_x_next : cur_y_next;
    assign last       = single_reg || (major_next == stop_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (emit && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_WALK:
            begin
                emit = !out_valid_reg || out_pop;
            end
            default:
            begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_x_reg     <= q_data.start_x;
            cur_y_reg     <= q_data.start_y;
            stop_reg      <= q_data.stop_coord;
            err_reg       <= q_data.error_init;
            inc_minor_reg <= q_data.inc_minor_step;
            inc_no_reg    <= q_data.inc_no_step;
            steps_reg     <= q_data.steps;
            x_major_reg   <= q_data.x_major;
            single_reg    <= q_data.single;
        end
        else if (emit)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
        end
        if (emit)
        begin
            out_reg.point_x <= cur_x_reg;
            out_reg.point_y <= cur_y_reg;
            out_reg.is_last <= last;
        end
    end

    assign point = out_reg;
    assign empty = !out_valid_reg;

    a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("setup taken while walking");

    a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (state_reg == ST_IDLE))
        else $error("walk did not end after last point");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || pop))
        else $error("waiting point overwritten");

endmodule

/* sim/line_point_rasterizer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_point_rasterizer_test
// Self-checking bench for the Bresenham line rasterizer. Line requests go in
// through the push/full queue port in random bursts, and points are drained
// through empty/pop on a changing stall pattern. The bench walks each
// accepted line itself and compares every point, field by field, in order.
// ----------------------------------------------------------------------------
module line_point_rasterizer_test;
    import lpr_pkg::*;

    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int RANDOM_LINES   = 87;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * (COORD_MAX + 2);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_t;

    class point_scoreboard;
        point_t expected_points[$];
        int     errors;
        int     lines_seen;

        function new();
            errors     = 0;
            lines_seen = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        // Walk the line the way the block does and queue its points
        function void note_line(line_t l);
            coord_t cx;
            coord_t cy;
            coord_t px;
            coord_t py;
            coord_t sx;
            coord_t sy;
            int     dx;
            int     dy;
            int     ax;
            int     ay;
            int     err;
            point_t p;
            lines_seen++;
            dx = int'(l.x_end) - int'(l.x_start);
            dy = int'(l.y_end) - int'(l.y_start);
            ax = 2 * ((dx < 0) ? -dx : dx);
            ay = 2 * ((dy < 0) ? -dy : dy);
            sx = (dx > 0) ? coord_t'(1) : ((dx < 0) ? coord_t'(COORD_MAX) : coord_t'(0));
            sy = (dy > 0) ? coord_t'(1) : ((dy < 0) ? coord_t'(COORD_MAX) : coord_t'(0));
            cx = l.x_start;
            cy = l.y_start;
            if (dx == 0 && dy == 0)
            begin
                p.point_x = cx;
                p.point_y = cy;
                p.is_last = 1'b1;
                expected_points.push_back(p);
            end
            else if (ax > ay)
            begin
                err = ay - ax / 2;
                while (cx != l.x_end)
                begin
                    px = cx;
                    py = cy;
                    if (err >= 0)
                    begin
                        cy  = cy + sy;
                        err = err + ay - ax;
                    end
                    else
                    begin
                        err = err + ay;
                    end
                    cx = cx + sx;
                    p.point_x = px;
                    p.point_y = py;
                    p.is_last = (cx == l.x_end);
                    expected_points.push_back(p);
                end
            end
            else
            begin
                // y is the major axis, ties included
                err = ax - ay / 2;
                while (cy != l.y_end)
                begin
                    px = cx;
                    py = cy;
                    if (err >= 0)
                    begin
                        cx  = cx + sx;
                        err = err + ax - ay;
                    end
                    else
                    begin
                        err = err + ax;
                    end
                    cy = cy + sy;
                    p.point_x = px;
                    p.point_y = py;
                    p.is_last = (cy == l.y_end);
                    expected_points.push_back(p);
                end
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0)
            begin
                flag($sformatf("unexpected point x=%0d y=%0d last=%0d",
                               got.point_x, got.point_y, got.is_last));
            end
            else
            begin
                want = expected_points.pop_front();
                if (got.point_x != want.point_x || got.point_y != want.point_y ||
                    got.is_last != want.is_last)
                begin
                    flag($sformatf("expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                                   want.point_x, want.point_y, want.is_last,
                                   got.point_x, got.point_y, got.is_last));
                end
            end
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n;
    logic   push;
    logic   full;
    line_t  line;
    logic   empty;
    logic   pop;
    point_t point;

    point_scoreboard sb = new();
    int stall_cycles = 0;
    int burst_left   = 1;
    bit moved;

    line_point_rasterizer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .line  (line),
        .empty (empty),
        .pop   (pop),
        .point (point)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sample both handshakes on the rising edge; watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                sb.note_line(line);
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                sb.check_point(point);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Hold the request until accepted; at the end of a burst, add a random gap (or none)
    task automatic offer_line(line_t l);
        int gap;
        @(negedge clk);
        line = l;
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                push = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    function automatic line_t make_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        line_t l;
        l.x_start = xs;
        l.y_start = ys;
        l.x_end   = xe;
        l.y_end   = ye;
        return l;
    endfunction

    function automatic coord_t near_coord(coord_t c);
        int v;
        v = int'(c) + $urandom_range(0, 8) - 4;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return coord_t'(v);
    endfunction

    function automatic line_t random_line();
        line_t       l;
        int          kind;
        logic [31:0] r;
        r    = $urandom;
        l    = r[$bits(line_t)-1:0];
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            l.x_end = l.x_start;
            l.y_end = l.y_start;
        end
        else if (kind <= 3)
        begin
            // short lines keep the walker busy with many small requests
            l.x_end = near_coord(l.x_start);
            l.y_end = near_coord(l.y_start);
        end
        return l;
    endfunction

    // Receiver: switch stall pattern at random intervals, with one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       phase_left;
        int       hold_left;
        bit       hold_done;
        pop        = 1'b0;
        mode       = RX_STREAM;
        phase_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.lines_seen >= 25)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 80);
                end
                phase_left--;
                case (mode)
                    RX_STREAM:  pop = 1'b1;
                    RX_COIN:    pop = 1'($urandom_range(0, 1));
                    RX_SPARSE:  pop = ($urandom_range(0, 3) == 0);
                    default:    pop = ((phase_left % 5) != 0);
                endcase
            end
        end
    end

    initial
    begin
        line_t directed[$];
        push  = 1'b0;
        line  = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // degenerate lines at both corners
        directed.push_back(make_line(0, 0, 0, 0));
        directed.push_back(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        // full-length axis lines both ways
        directed.push_back(make_line(0, 0, COORD_MAX, 0));
        directed.push_back(make_line(COORD_MAX, 0, 0, 0));
        directed.push_back(make_line(0, 0, 0, COORD_MAX));
        directed.push_back(make_line(0, COORD_MAX, 0, 0));
        // full diagonals: tie goes to y major
        directed.push_back(make_line(0, 0, COORD_MAX, COORD_MAX));
        directed.push_back(make_line(COORD_MAX, COORD_MAX, 0, 0));
        directed.push_back(make_line(0, COORD_MAX, COORD_MAX, 0));
        directed.push_back(make_line(COORD_MAX, 0, 0, COORD_MAX));
        // one line per octant
        directed.push_back(make_line(10, 10, 40, 20));
        directed.push_back(make_line(40, 20, 10, 10));
        directed.push_back(make_line(10, 10, 20, 40));
        directed.push_back(make_line(20, 40, 10, 10));
        directed.push_back(make_line(5, 50, 50, 40));
        directed.push_back(make_line(50, 40, 5, 50));
        directed.push_back(make_line(30, 5, 20, 60));
        directed.push_back(make_line(20, 60, 30, 5));
        // single-step lines
        directed.push_back(make_line(3, 3, 4, 3));
        directed.push_back(make_line(3, 3, 3, 2));
        directed.push_back(make_line(7, 7, 8, 8));
        // alternating bit patterns
        directed.push_back(make_line(21, 42, 42, 21));
        directed.push_back(make_line(42, 21, 21, 42));
        foreach (directed[i])
        begin
            offer_line(directed[i]);
        end

        repeat (RANDOM_LINES)
        begin
            offer_line(random_line());
        end
        @(negedge clk);
        push = 1'b0;

        while (sb.expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
